// ----- src/aarx_pkg.sv -----
// Shared constants, types and tables for the azimuth/altitude/range to XYZ unit.
package aarx_pkg;

  // Angle units are 1/128 degree.
  localparam int unsigned FULL_TURN      = 46080;
  localparam int unsigned QUARTER_TURN   = 11520;
  localparam int unsigned EIGHTH_TURN    = 5760;
  localparam int unsigned HEADING_OFFSET = 57600;

  localparam longint unsigned PI_Q32    = 64'h0000_0003_243F_6A89;
  localparam longint unsigned ONE_Q30   = 64'd1 << 30;
  localparam longint unsigned ROUND_Q30 = 64'd1 << 29;

  // u * PI_Q32 / 92160 split into an integer part and a remainder part.
  localparam int unsigned X_SCALE_Q = 146408;
  localparam int unsigned X_SCALE_R = 76425;
  localparam int unsigned X_BIAS    = 46080;
  localparam int unsigned X_PRE_SHIFT = 11;
  localparam int unsigned X_DIV_SHIFT = 24;
  localparam longint unsigned X_DIV_RECIP = ((64'd1 << 24) + 64'd44) / 64'd45;

  // Heading in radians: ((hd * PI_Q32 + 45 * 2^24) >> 25) / 45.
  localparam longint unsigned HEAD_BIAS      = 64'd45 << 24;
  localparam int unsigned     HEAD_PRE_SHIFT = 25;
  localparam int unsigned     HEAD_DIV_SHIFT = 31;
  localparam longint unsigned HEAD_DIV_RECIP = ((64'd1 << 31) + 64'd44) / 64'd45;
  localparam int unsigned     HEAD_MAX       = 411774;

  localparam int unsigned NUM_ANG   = 2;
  localparam int unsigned LANE_HEAD = 0;
  localparam int unsigned LANE_ALT  = 1;

  // Horner steps; each divisor k is replaced by a reciprocal M and a shift S.
  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned SIN_SHIFT [HORNER_STEPS] = '{38, 37, 37, 36, 35, 33};
  localparam int unsigned COS_SHIFT [HORNER_STEPS] = '{38, 37, 36, 35, 34, 31};
  localparam longint unsigned SIN_RECIP [HORNER_STEPS] = '{
    ((64'd1 << 38) + 64'd155) / 64'd156,
    ((64'd1 << 37) + 64'd109) / 64'd110,
    ((64'd1 << 37) + 64'd71)  / 64'd72,
    ((64'd1 << 36) + 64'd41)  / 64'd42,
    ((64'd1 << 35) + 64'd19)  / 64'd20,
    ((64'd1 << 33) + 64'd5)   / 64'd6
  };
  localparam longint unsigned COS_RECIP [HORNER_STEPS] = '{
    ((64'd1 << 38) + 64'd131) / 64'd132,
    ((64'd1 << 37) + 64'd89)  / 64'd90,
    ((64'd1 << 36) + 64'd55)  / 64'd56,
    ((64'd1 << 35) + 64'd29)  / 64'd30,
    ((64'd1 << 34) + 64'd11)  / 64'd12,
    ((64'd1 << 31) + 64'd1)   / 64'd2
  };

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } aarx_quad_e;

  typedef struct packed {
    logic [18:0]                heading;
    logic [23:0]                range;
    aarx_quad_e [NUM_ANG-1:0]   quad;
    logic [NUM_ANG-1:0]         swap;
  } aarx_side_t;

endpackage

// ----- src/aarx_reduce.sv -----
// Angle wrap, quadrant/octant reduction and heading-to-radian conversion.
module aarx_reduce (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [16:0]     azim_i,
  input  logic signed [14:0]     elev_i,
  input  logic [23:0]            range_km_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [aarx_pkg::NUM_ANG-1:0][12:0] u_o,
  output aarx_pkg::aarx_side_t   side_o
);

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // Stage 0: wrap heading and altitude into one turn
  logic signed [17:0] hd_raw;
  logic signed [17:0] hd_wrap;
  logic signed [16:0] alt_ext;
  logic signed [16:0] alt_wrap;
  logic [15:0] hd_q, alt_q;
  logic [23:0] range0_q;

  always_comb begin
    hd_raw = 18'(aarx_pkg::HEADING_OFFSET) - 18'(azim_i);
    if (hd_raw < 0) begin
      hd_wrap = hd_raw + 18'(aarx_pkg::FULL_TURN);
    end else if (hd_raw >= 18'(2 * aarx_pkg::FULL_TURN)) begin
      hd_wrap = hd_raw - 18'(2 * aarx_pkg::FULL_TURN);
    end else if (hd_raw >= 18'(aarx_pkg::FULL_TURN)) begin
      hd_wrap = hd_raw - 18'(aarx_pkg::FULL_TURN);
    end else begin
      hd_wrap = hd_raw;
    end
    alt_ext  = 17'(elev_i);
    alt_wrap = (alt_ext < 0) ? alt_ext + 17'(aarx_pkg::FULL_TURN) : alt_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hd_q     <= hd_wrap[15:0];
      alt_q    <= alt_wrap[15:0];
      range0_q <= range_km_i;
    end
  end

  // Stage 1: quadrant split, mirror into the first octant, heading product
  logic [aarx_pkg::NUM_ANG-1:0][15:0] ang;
  logic [aarx_pkg::NUM_ANG-1:0][13:0] rem;
  logic [aarx_pkg::NUM_ANG-1:0][12:0] u_d;
  aarx_pkg::aarx_quad_e [aarx_pkg::NUM_ANG-1:0] quad_d;
  logic [aarx_pkg::NUM_ANG-1:0] swap_d;
  logic [49:0] head_prod;

  always_comb begin
    ang[aarx_pkg::LANE_HEAD] = hd_q;
    ang[aarx_pkg::LANE_ALT]  = alt_q;
    for (int l = 0; l < aarx_pkg::NUM_ANG; l++) begin
      if (ang[l] < 16'(aarx_pkg::QUARTER_TURN)) begin
        quad_d[l] = aarx_pkg::QUAD_I;
        rem[l]    = 14'(ang[l]);
      end else if (ang[l] < 16'(2 * aarx_pkg::QUARTER_TURN)) begin
        quad_d[l] = aarx_pkg::QUAD_II;
        rem[l]    = 14'(ang[l] - 16'(aarx_pkg::QUARTER_TURN));
      end else if (ang[l] < 16'(3 * aarx_pkg::QUARTER_TURN)) begin
        quad_d[l] = aarx_pkg::QUAD_III;
        rem[l]    = 14'(ang[l] - 16'(2 * aarx_pkg::QUARTER_TURN));
      end else begin
        quad_d[l] = aarx_pkg::QUAD_IV;
        rem[l]    = 14'(ang[l] - 16'(3 * aarx_pkg::QUARTER_TURN));
      end
      swap_d[l] = rem[l] > 14'(aarx_pkg::EIGHTH_TURN);
      u_d[l]    = swap_d[l] ? 13'(14'(aarx_pkg::QUARTER_TURN) - rem[l]) : 13'(rem[l]);
    end
    head_prod = 50'(hd_q) * 50'(aarx_pkg::PI_Q32) + 50'(aarx_pkg::HEAD_BIAS);
  end

  logic [aarx_pkg::NUM_ANG-1:0][12:0] u1_q;
  aarx_pkg::aarx_quad_e [aarx_pkg::NUM_ANG-1:0] quad1_q;
  logic [aarx_pkg::NUM_ANG-1:0] swap1_q;
  logic [24:0] head_n_q;
  logic [23:0] range1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      u1_q     <= u_d;
      quad1_q  <= quad_d;
      swap1_q  <= swap_d;
      head_n_q <= 25'(head_prod >> aarx_pkg::HEAD_PRE_SHIFT);
      range1_q <= range0_q;
    end
  end

  // Stage 2: divide the heading by 45 through its reciprocal
  logic [50:0] head_div;
  aarx_pkg::aarx_side_t side_d;
  logic [aarx_pkg::NUM_ANG-1:0][12:0] u2_q;
  aarx_pkg::aarx_side_t side2_q;

  always_comb begin
    head_div       = 51'(head_n_q) * 51'(aarx_pkg::HEAD_DIV_RECIP);
    side_d.heading = 19'(head_div >> aarx_pkg::HEAD_DIV_SHIFT);
    side_d.range   = range1_q;
    side_d.quad    = quad1_q;
    side_d.swap    = swap1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      u2_q    <= u1_q;
      side2_q <= side_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign u_o         = u2_q;
  assign side_o      = side2_q;

endmodule

// ----- src/aarx_trig.sv -----
// Pipelined fixed-point sine/cosine of two first-octant angles (Taylor/Horner form).
module aarx_trig (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [aarx_pkg::NUM_ANG-1:0][12:0] u_i,
  input  aarx_pkg::aarx_side_t   side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [aarx_pkg::NUM_ANG-1:0][30:0] sin_mag_o,
  output logic [aarx_pkg::NUM_ANG-1:0][30:0] cos_mag_o,
  output aarx_pkg::aarx_side_t   side_o
);

  localparam int unsigned NumSteps  = aarx_pkg::HORNER_STEPS;
  localparam int unsigned NumStages = 5 + 2 * NumSteps;
  localparam int unsigned LastDiv   = 3 + 2 * NumSteps;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  aarx_pkg::aarx_side_t side_q [NumStages];

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_i;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < aarx_pkg::NUM_ANG; l++) begin : g_lane
    logic [28:0] frac_q;
    logic [29:0] base0_q, base1_q;
    logic [12:0] quo_q;
    logic [29:0] x_q  [2:LastDiv];
    logic [29:0] x2_q [3:LastDiv-2];
    logic [29:0] ys_q [NumSteps];
    logic [29:0] yc_q [NumSteps];
    logic [30:0] ts_q [NumSteps];
    logic [30:0] tc_q [NumSteps];
    logic [30:0] ts_in [NumSteps];
    logic [30:0] tc_in [NumSteps];
    logic [60:0] ys_prod [NumSteps];
    logic [60:0] yc_prod [NumSteps];
    logic [60:0] qs_prod [NumSteps];
    logic [60:0] qc_prod [NumSteps];
    logic [36:0] quo_prod;
    logic [59:0] sq_prod;
    logic [60:0] sin_prod;
    logic [30:0] sin_q, cos_q;

    always_comb begin
      quo_prod = 37'(frac_q >> aarx_pkg::X_PRE_SHIFT) * 37'(aarx_pkg::X_DIV_RECIP);
      sq_prod  = 60'(x_q[2]) * 60'(x_q[2]) + 60'(aarx_pkg::ROUND_Q30);
      sin_prod = 61'(x_q[LastDiv]) * 61'(ts_q[NumSteps-1]);
      ts_in[0] = 31'(aarx_pkg::ONE_Q30);
      tc_in[0] = 31'(aarx_pkg::ONE_Q30);
      for (int j = 1; j < NumSteps; j++) begin
        ts_in[j] = ts_q[j-1];
        tc_in[j] = tc_q[j-1];
      end
      for (int j = 0; j < NumSteps; j++) begin
        ys_prod[j] = 61'(x2_q[3+2*j]) * 61'(ts_in[j]);
        yc_prod[j] = 61'(x2_q[3+2*j]) * 61'(tc_in[j]);
        qs_prod[j] = 61'(ys_q[j]) * 61'(aarx_pkg::SIN_RECIP[j]);
        qc_prod[j] = 61'(yc_q[j]) * 61'(aarx_pkg::COS_RECIP[j]);
      end
    end

    always_ff @(posedge clk_i) begin
      // convert the octant angle to Q30 radians
      if (en[0]) begin
        frac_q  <= 29'(32'(u_i[l]) * 32'(aarx_pkg::X_SCALE_R) + 32'(aarx_pkg::X_BIAS));
        base0_q <= 30'(32'(u_i[l]) * 32'(aarx_pkg::X_SCALE_Q));
      end
      if (en[1]) begin
        quo_q   <= 13'(quo_prod >> aarx_pkg::X_DIV_SHIFT);
        base1_q <= base0_q;
      end
      if (en[2]) begin
        x_q[2] <= base1_q + 30'(quo_q);
      end
      if (en[3]) begin
        x2_q[3] <= 30'(sq_prod >> 30);
      end
      for (int k = 3; k <= LastDiv; k++) begin
        if (en[k]) begin
          x_q[k] <= x_q[k-1];
        end
      end
      for (int k = 4; k <= LastDiv - 2; k++) begin
        if (en[k]) begin
          x2_q[k] <= x2_q[k-1];
        end
      end
      // Horner: multiply stage, then reciprocal-divide and subtract stage
      for (int j = 0; j < NumSteps; j++) begin
        if (en[4+2*j]) begin
          ys_q[j] <= 30'(ys_prod[j] >> 30);
          yc_q[j] <= 30'(yc_prod[j] >> 30);
        end
        if (en[5+2*j]) begin
          ts_q[j] <= 31'(aarx_pkg::ONE_Q30) - 31'(qs_prod[j] >> aarx_pkg::SIN_SHIFT[j]);
          tc_q[j] <= 31'(aarx_pkg::ONE_Q30) - 31'(qc_prod[j] >> aarx_pkg::COS_SHIFT[j]);
        end
      end
      if (en[NumStages-1]) begin
        sin_q <= 31'(sin_prod >> 30);
        cos_q <= tc_q[NumSteps-1];
      end
    end

    assign sin_mag_o[l] = sin_q;
    assign cos_mag_o[l] = cos_q;
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign side_o      = side_q[NumStages-1];

endmodule

// ----- src/aarx_scale.sv -----
// Quadrant signs, trig products and range scaling to rounded meters.
module aarx_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [aarx_pkg::NUM_ANG-1:0][30:0] sin_mag_i,
  input  logic [aarx_pkg::NUM_ANG-1:0][30:0] cos_mag_i,
  input  aarx_pkg::aarx_side_t   side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [18:0]            heading_rad_o,
  output logic [26:0]            pos_x_o,
  output logic [26:0]            pos_y_o,
  output logic [26:0]            pos_z_o
);

  localparam int unsigned NumStages = 4;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned AxisX     = 0;
  localparam int unsigned AxisY     = 1;
  localparam int unsigned AxisZ     = 2;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // Stage 0: undo the octant mirror, apply quadrant signs, form trig products
  logic [aarx_pkg::NUM_ANG-1:0][30:0] st, ct, sn, cs;
  logic [aarx_pkg::NUM_ANG-1:0] sn_neg, cs_neg;
  logic [61:0] prod_x, prod_y;
  logic [NumAxes-1:0][30:0] ab_d;
  logic [NumAxes-1:0] neg_d;

  always_comb begin
    for (int l = 0; l < aarx_pkg::NUM_ANG; l++) begin
      st[l] = side_i.swap[l] ? cos_mag_i[l] : sin_mag_i[l];
      ct[l] = side_i.swap[l] ? sin_mag_i[l] : cos_mag_i[l];
      case (side_i.quad[l])
        aarx_pkg::QUAD_I: begin
          sn[l] = st[l]; sn_neg[l] = 1'b0; cs[l] = ct[l]; cs_neg[l] = 1'b0;
        end
        aarx_pkg::QUAD_II: begin
          sn[l] = ct[l]; sn_neg[l] = 1'b0; cs[l] = st[l]; cs_neg[l] = 1'b1;
        end
        aarx_pkg::QUAD_III: begin
          sn[l] = st[l]; sn_neg[l] = 1'b1; cs[l] = ct[l]; cs_neg[l] = 1'b1;
        end
        default: begin
          sn[l] = ct[l]; sn_neg[l] = 1'b1; cs[l] = st[l]; cs_neg[l] = 1'b0;
        end
      endcase
    end
    prod_x = 62'(cs[aarx_pkg::LANE_HEAD]) * 62'(cs[aarx_pkg::LANE_ALT])
             + 62'(aarx_pkg::ROUND_Q30);
    prod_y = 62'(sn[aarx_pkg::LANE_HEAD]) * 62'(cs[aarx_pkg::LANE_ALT])
             + 62'(aarx_pkg::ROUND_Q30);
    ab_d[AxisX]  = 31'(prod_x >> 30);
    ab_d[AxisY]  = 31'(prod_y >> 30);
    ab_d[AxisZ]  = sn[aarx_pkg::LANE_ALT];
    neg_d[AxisX] = cs_neg[aarx_pkg::LANE_HEAD] ^ cs_neg[aarx_pkg::LANE_ALT];
    neg_d[AxisY] = !(sn_neg[aarx_pkg::LANE_HEAD] ^ cs_neg[aarx_pkg::LANE_ALT]);
    neg_d[AxisZ] = sn_neg[aarx_pkg::LANE_ALT];
  end

  logic [NumAxes-1:0][30:0] ab_q;
  logic [NumAxes-1:0] neg0_q, neg1_q, neg2_q;
  logic [23:0] range0_q;
  logic [18:0] head0_q, head1_q, head2_q, head3_q;
  logic [NumAxes-1:0][54:0] p_q;
  logic [NumAxes-1:0][25:0] m_q;
  logic [NumAxes-1:0][26:0] pos_q;
  logic [NumAxes-1:0][64:0] scaled;

  // Times 1000 as 1024 - 16 - 8, plus the half for rounding at bit 38
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      scaled[a] = (65'(p_q[a]) << 10) - (65'(p_q[a]) << 4) - (65'(p_q[a]) << 3)
                  + (65'd1 << 37);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ab_q     <= ab_d;
      neg0_q   <= neg_d;
      range0_q <= side_i.range;
      head0_q  <= side_i.heading;
    end
    if (en[1]) begin
      for (int a = 0; a < NumAxes; a++) begin
        p_q[a] <= 55'(ab_q[a]) * 55'(range0_q);
      end
      neg1_q  <= neg0_q;
      head1_q <= head0_q;
    end
    if (en[2]) begin
      for (int a = 0; a < NumAxes; a++) begin
        m_q[a] <= 26'(scaled[a] >> 38);
      end
      neg2_q  <= neg1_q;
      head2_q <= head1_q;
    end
    if (en[3]) begin
      for (int a = 0; a < NumAxes; a++) begin
        pos_q[a] <= neg2_q[a] ? 27'(-{1'b0, m_q[a]}) : {1'b0, m_q[a]};
      end
      head3_q <= head2_q;
    end
  end

  assign in_ready_o    = en[0];
  assign out_valid_o   = valid_q[NumStages-1];
  assign heading_rad_o = head3_q;
  assign pos_x_o       = pos_q[AxisX];
  assign pos_y_o       = pos_q[AxisY];
  assign pos_z_o       = pos_q[AxisZ];

endmodule

// ----- src/azimuth_altitude_range_to_xyz_unit.sv -----
// Top level of the azimuth/altitude/range to Cartesian position converter.
//
//  channel   | direction | width | contents (low bit up)
//  ----------+-----------+-------+-----------------------------------------------
//  s_axis    | in        | 56    | azimuth[16:0], elevation[31:17],
//            |           |       | range_km[55:32]
//  m_axis    | out       | 104   | heading_rad[18:0], pos_x[45:19], pos_y[72:46],
//            |           |       | pos_z[99:73], zero pad [103:100]
//
// From acceptance to a valid result a request passes through 3 reduction
// stages, 17 trig stages (4 for the radian conversion and square, 12 for the
// six Horner steps, 1 for the final sine product) and 4 scaling stages.
// Throughput is one request per cycle while m_axis is not stalled.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage moves when it is empty or the stage after it moves, so a stall on
// m_axis holds everything and bubbles are squeezed out behind it.
module azimuth_altitude_range_to_xyz_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // azimuth [16:0], elevation [31:17], range_km [55:32]
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // heading_rad [18:0], pos_x [45:19], pos_y [72:46], pos_z [99:73], zeros [103:100]
  output logic [103:0] m_axis_tdata
);

  // Reduction -> trig link
  logic red_valid, red_ready;
  logic [aarx_pkg::NUM_ANG-1:0][12:0] red_u;
  aarx_pkg::aarx_side_t red_side;

  // Trig -> scaling link
  logic trig_valid, trig_ready;
  logic [aarx_pkg::NUM_ANG-1:0][30:0] trig_sin, trig_cos;
  aarx_pkg::aarx_side_t trig_side;

  logic [18:0] heading_rad;
  logic [26:0] pos_x, pos_y, pos_z;

  // Wrap both angles, fold into the first octant, convert heading to radians
  aarx_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .azim_i      (s_axis_tdata[16:0]),
    .elev_i      (s_axis_tdata[31:17]),
    .range_km_i  (s_axis_tdata[55:32]),
    .out_valid_o (red_valid),
    .out_ready_i (red_ready),
    .u_o         (red_u),
    .side_o      (red_side)
  );

  // Sine and cosine magnitudes of heading and altitude lanes
  aarx_trig u_trig (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (red_ready),
    .u_i         (red_u),
    .side_i      (red_side),
    .out_valid_o (trig_valid),
    .out_ready_i (trig_ready),
    .sin_mag_o   (trig_sin),
    .cos_mag_o   (trig_cos),
    .side_o      (trig_side)
  );

  // Apply signs, multiply out and scale by range; last stage is the output register
  aarx_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (trig_valid),
    .in_ready_o    (trig_ready),
    .sin_mag_i     (trig_sin),
    .cos_mag_i     (trig_cos),
    .side_i        (trig_side),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .heading_rad_o (heading_rad),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .pos_z_o       (pos_z)
  );

  assign m_axis_tdata = {4'b0000, pos_z, pos_y, pos_x, heading_rad};

  // An empty output stage means every stage can move, so input must be open
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  // Octant reduction never hands the trig unit more than an eighth turn
  a_octant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_valid |-> (red_u[aarx_pkg::LANE_HEAD] <= 13'(aarx_pkg::EIGHTH_TURN)) &&
                  (red_u[aarx_pkg::LANE_ALT] <= 13'(aarx_pkg::EIGHTH_TURN)))
    else $error("reduced angle beyond one octant");

  // Trig magnitudes stay within one in Q30
  a_trig_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_valid |-> (trig_sin[aarx_pkg::LANE_HEAD] <= 31'(aarx_pkg::ONE_Q30)) &&
                   (trig_sin[aarx_pkg::LANE_ALT] <= 31'(aarx_pkg::ONE_Q30)) &&
                   (trig_cos[aarx_pkg::LANE_HEAD] <= 31'(aarx_pkg::ONE_Q30)) &&
                   (trig_cos[aarx_pkg::LANE_ALT] <= 31'(aarx_pkg::ONE_Q30)))
    else $error("trig magnitude above one");

  // Heading in radians stays below two pi
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:0] <= 19'(aarx_pkg::HEAD_MAX))
    else $error("heading out of range");

endmodule
